/* hdl/tjfcc_pkg.sv */
`default_nettype none
package tjfcc_pkg;

  // Field widths
  localparam int PosW   = 32;
  localparam int SpdW   = 32;
  localparam int DtW    = 16;
  localparam int IdxW   = 3;
  // Extra headroom for position plus or minus a full-range delta
  localparam int SumW   = PosW + 2;

  // Stream packing
  localparam int InDataW  = 56;
  localparam int OutDataW = 72;

  // Command selector carried in tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_P_LOW  = 3'd0;
  localparam logic [IdxW-1:0] REG_P_HIGH = 3'd1;
  localparam logic [IdxW-1:0] REG_D_LOW  = 3'd2;
  localparam logic [IdxW-1:0] REG_D_HIGH = 3'd3;
  localparam logic [IdxW-1:0] REG_P_SPD  = 3'd4;
  localparam logic [IdxW-1:0] REG_D_SPD  = 3'd5;

  // Configuration reset values
  localparam logic signed [PosW-1:0] P_LOW_RST  = 32'sd0;
  localparam logic signed [PosW-1:0] P_HIGH_RST = 32'sd160000;
  localparam logic signed [PosW-1:0] D_LOW_RST  = 32'sd0;
  localparam logic signed [PosW-1:0] D_HIGH_RST = 32'sd55000;
  localparam logic [SpdW-1:0]        P_SPD_RST  = 32'd65536;
  localparam logic [SpdW-1:0]        D_SPD_RST  = 32'd65536;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_REJECT  = 3'd1,
    ST_CONTACT = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_GOAL    = 3'd4,
    ST_IDLE    = 3'd5
  } status_t;

  // Outcome of one joint ramp step
  typedef struct packed {
    logic                   hit;
    logic signed [PosW-1:0] pos;
  } ramp_res_t;

endpackage
`default_nettype wire

/* hdl/tjfcc_ramp.sv */
`default_nettype none
// One joint ramp: move by delta in the given direction, stop at the target.
module tjfcc_ramp import tjfcc_pkg::*; (
  input  wire logic signed [PosW-1:0] pos,
  input  wire logic        [SpdW-1:0] delta,
  input  wire logic                   up,
  input  wire logic signed [PosW-1:0] hi_target,
  input  wire logic signed [PosW-1:0] lo_target,
  output ramp_res_t                   res
);

  logic signed [SumW-1:0] pos_x;
  logic signed [SumW-1:0] delta_x;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] hi_x;
  logic signed [SumW-1:0] lo_x;

  // Sign-extend position and targets, zero-extend the unsigned delta
  assign pos_x   = SumW'(pos);
  assign delta_x = $signed({2'b00, delta});
  assign hi_x    = SumW'(hi_target);
  assign lo_x    = SumW'(lo_target);

  assign sum = up ? (pos_x + delta_x) : (pos_x - delta_x);

  // Reaching or passing the target lands exactly on it
  always_comb begin
    if (up) begin
      res.hit = (sum >= hi_x);
      res.pos = res.hit ? hi_target : sum[PosW-1:0];
    end else begin
      res.hit = (sum <= lo_x);
      res.pos = res.hit ? lo_target : sum[PosW-1:0];
    end
  end

endmodule
`default_nettype wire

/* hdl/two_joint_finger_closing_controller_unit.sv */
`default_nettype none
// Channel  Dir  tdata (low bit up)                                  tuser
// in       in   goal_position[31:0] time_step[47:32]                cmd
//               distal_contact[48] proximal_contact[49] pad[55:50]
// out      out  proximal_position[31:0] distal_position[63:32]      -
//               busy_res[64] status[67:65] pad[71:68]
// cfg      in   cfg_wr_en, cfg_index (3 bit), cfg_wr_data (32 bit)  -
//
// One beat per cycle sustained while out_tready stays high; results leave from stage two.
// Stage one registers the beat and the two speed-times-step products; stage two
// does the ramp add and compare, updates the joint state and loads the result.
// rst_n is synchronous: state is cleared, configuration returns to defaults.
// A stalled result holds both stages; in_tready drops only when both are full.
module two_joint_finger_closing_controller_unit import tjfcc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input stream
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,  // goal, time_step, distal_c, proximal_c
  input  wire logic                in_tuser,  // cmd
  // result stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata, // prox pos, dist pos, busy_res, status
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [IdxW-1:0]     cfg_index,
  input  wire logic [SpdW-1:0]     cfg_wr_data
);

  // Configuration registers
  logic signed [PosW-1:0] p_low_r, p_high_r, d_low_r, d_high_r;
  logic        [SpdW-1:0] p_spd_r, d_spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_low_r  <= P_LOW_RST;
      p_high_r <= P_HIGH_RST;
      d_low_r  <= D_LOW_RST;
      d_high_r <= D_HIGH_RST;
      p_spd_r  <= P_SPD_RST;
      d_spd_r  <= D_SPD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_P_LOW:  p_low_r  <= $signed(cfg_wr_data);
        REG_P_HIGH: p_high_r <= $signed(cfg_wr_data);
        REG_D_LOW:  d_low_r  <= $signed(cfg_wr_data);
        REG_D_HIGH: d_high_r <= $signed(cfg_wr_data);
        REG_P_SPD:  p_spd_r  <= cfg_wr_data;
        REG_D_SPD:  d_spd_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic s1_v_r, out_v_r;
  logic out_en, s1_en, adv;

  assign out_en    = !out_v_r || out_tready;
  assign s1_en     = !s1_v_r || out_en;
  assign adv       = s1_v_r && out_en;
  assign in_tready = s1_en;

  // Input fields
  logic signed [PosW-1:0] in_goal;
  logic        [DtW-1:0]  in_dt;
  logic                   in_dc, in_pc;

  assign in_goal = $signed(in_tdata[31:0]);
  assign in_dt   = in_tdata[47:32];
  assign in_dc   = in_tdata[48];
  assign in_pc   = in_tdata[49];

  // Ramp deltas: (time_step * speed) >> 16
  localparam int ProdW = DtW + SpdW;
  logic [ProdW-1:0] p_prod, d_prod;

  assign p_prod = ProdW'(in_dt) * ProdW'(p_spd_r);
  assign d_prod = ProdW'(in_dt) * ProdW'(d_spd_r);

  // Stage one
  logic                   s1_cmd_r, s1_dc_r, s1_pc_r;
  logic signed [PosW-1:0] s1_goal_r;
  logic        [SpdW-1:0] s1_pd_r, s1_dd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_goal_r <= in_goal;
      s1_dc_r   <= in_dc;
      s1_pc_r   <= in_pc;
      s1_pd_r   <= p_prod[ProdW-1:DtW];
      s1_dd_r   <= d_prod[ProdW-1:DtW];
    end
  end

  // Joint state
  logic signed [PosW-1:0] inner_r, inner_nxt;
  logic signed [PosW-1:0] outer_r, outer_nxt;
  logic signed [PosW-1:0] goal_r, goal_nxt;
  logic                   moving_r, moving_nxt;
  logic                   oonly_r, oonly_nxt;
  status_t                st_nxt;

  logic      up;
  ramp_res_t d_ramp, p_ramp;

  assign up = (inner_r < goal_r);

  tjfcc_ramp u_distal_ramp (
    .pos       (outer_r),
    .delta     (s1_dd_r),
    .up        (up),
    .hi_target (d_high_r),
    .lo_target (d_low_r),
    .res       (d_ramp)
  );

  tjfcc_ramp u_proximal_ramp (
    .pos       (inner_r),
    .delta     (s1_pd_r),
    .up        (up),
    .hi_target (goal_r),
    .lo_target (goal_r),
    .res       (p_ramp)
  );

  // Start and tick handling
  always_comb begin
    inner_nxt  = inner_r;
    outer_nxt  = outer_r;
    goal_nxt   = goal_r;
    moving_nxt = moving_r;
    oonly_nxt  = oonly_r;
    st_nxt     = ST_OK;
    if (s1_cmd_r == CMD_START) begin
      if (moving_r) begin
        st_nxt = ST_REJECT;
      end else begin
        // low test wins when the limits are crossed
        priority if (s1_goal_r < p_low_r) begin
          goal_nxt = p_low_r;
        end else if (s1_goal_r > p_high_r) begin
          goal_nxt = p_high_r;
        end else begin
          goal_nxt = s1_goal_r;
        end
        moving_nxt = 1'b1;
        oonly_nxt  = 1'b0;
      end
    end else begin
      priority if (!moving_r) begin
        st_nxt = ST_IDLE;
      end else if (s1_dc_r) begin
        moving_nxt = 1'b0;
        st_nxt     = ST_CONTACT;
      end else if (d_ramp.hit) begin
        outer_nxt  = d_ramp.pos;
        moving_nxt = 1'b0;
        st_nxt     = ST_LIMIT;
      end else begin
        outer_nxt = d_ramp.pos;
        if (oonly_r) begin
          st_nxt = ST_OK;
        end else if (s1_pc_r) begin
          oonly_nxt = 1'b1;
        end else begin
          inner_nxt = p_ramp.pos;
          if (p_ramp.hit) begin
            moving_nxt = 1'b0;
            st_nxt     = ST_GOAL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r  <= '0;
      outer_r  <= '0;
      goal_r   <= '0;
      moving_r <= 1'b0;
      oonly_r  <= 1'b0;
    end else if (adv) begin
      inner_r  <= inner_nxt;
      outer_r  <= outer_nxt;
      goal_r   <= goal_nxt;
      moving_r <= moving_nxt;
      oonly_r  <= oonly_nxt;
    end
  end

  // Result register
  logic signed [PosW-1:0] out_prox_r, out_dist_r;
  logic                   out_busy_r;
  status_t                out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_prox_r <= inner_nxt;
      out_dist_r <= outer_nxt;
      out_busy_r <= moving_nxt;
      out_st_r   <= st_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_st_r, out_busy_r, out_dist_r, out_prox_r};

  // Checks
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_st_r == ST_REJECT) |-> out_busy_r)
    else $error("rejected start reported without busy");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_st_r == ST_CONTACT || out_st_r == ST_LIMIT ||
                out_st_r == ST_GOAL || out_st_r == ST_IDLE) |-> !out_busy_r)
    else $error("ended or idle result still busy");

  a_goal_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_st_r == ST_GOAL) |-> (out_prox_r == goal_r))
    else $error("goal status without inner joint on goal");

  a_fell_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(moving_r) && $past(rst_n) |-> $past(adv))
    else $error("motion ended without an item passing");

endmodule
`default_nettype wire
